[rtl/drpc_pkg.sv]
package drpc_pkg;

  localparam int unsigned TpsW = 10;
  localparam int unsigned SecW = 16;
  localparam logic [TpsW-1:0] TpsReset = 10'd100;

  localparam logic [7:0] CmdSet       = 8'h50;
  localparam logic [7:0] CmdPulseOne  = 8'h51;
  localparam logic [7:0] CmdPulseTwo  = 8'h52;
  localparam logic [7:0] CmdPulseBoth = 8'h53;
  localparam logic [7:0] CmdQuery     = 8'h60;

  localparam int unsigned RelayOneIdx = 0;
  localparam int unsigned RelayTwoIdx = 1;

  typedef struct packed {
    logic       command_valid;
    logic [7:0] command_code;
    logic [7:0] param_high;
    logic [7:0] param_low;
  } in_item_t;

  typedef struct packed {
    logic       relay_one_level;
    logic       relay_two_level;
    logic       reply_valid;
    logic [1:0] reply_status;
  } out_item_t;

  // decoded command of one beat
  typedef struct packed {
    logic set;
    logic pulse_one;
    logic pulse_two;
    logic query;
  } cmd_dec_t;

  // per-channel pulse request from the command decode
  typedef struct packed {
    logic            start;
    logic [SecW-1:0] length;
  } chan_req_t;

  // per-channel effect on the relay level
  typedef struct packed {
    logic drive_on;
    logic drive_off;
  } chan_act_t;

endpackage

[rtl/drpc_cmd_dec.sv]
module drpc_cmd_dec
  import drpc_pkg::*;
(
  input  in_item_t item,
  output cmd_dec_t dec
);

  always_comb begin
    dec = '0;
    if (item.command_valid) begin
      unique case (item.command_code)
        CmdSet: begin
          dec.set = 1'b1;
        end
        CmdPulseOne: begin
          dec.pulse_one = 1'b1;
        end
        CmdPulseTwo: begin
          dec.pulse_two = 1'b1;
        end
        CmdPulseBoth: begin
          dec.pulse_one = 1'b1;
          dec.pulse_two = 1'b1;
        end
        CmdQuery: begin
          dec.query = 1'b1;
        end
        default: begin
          dec = '0;
        end
      endcase
    end
  end

endmodule

[rtl/drpc_pulse_chan.sv]
module drpc_pulse_chan
  import drpc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  chan_req_t       req,
  input  logic [TpsW-1:0] tps,
  output chan_act_t       act
);

  logic            busy_r, busy_nxt;
  logic            pend_r, pend_nxt;
  logic [TpsW-1:0] tick_r, tick_nxt;
  logic [SecW-1:0] sec_r, sec_nxt;
  logic [SecW-1:0] len_r, len_nxt;

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r | req.start;
    tick_nxt = tick_r;
    sec_nxt  = sec_r;
    len_nxt  = req.start ? req.length : len_r;
    act      = '0;
    if (!busy_r) begin
      if (pend_nxt) begin
        pend_nxt     = 1'b0;
        busy_nxt     = 1'b1;
        act.drive_on = 1'b1;
      end
    end else begin
      tick_nxt = tick_r + 1'b1;
      if (tick_nxt >= tps) begin
        tick_nxt = '0;
        sec_nxt  = sec_r + 1'b1;
      end
      // new length applies at once, so compare against the updated one
      if (sec_nxt >= len_nxt) begin
        tick_nxt      = '0;
        sec_nxt       = '0;
        busy_nxt      = 1'b0;
        act.drive_off = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      tick_r <= '0;
      sec_r  <= '0;
      len_r  <= '0;
    end else if (advance) begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      tick_r <= tick_nxt;
      sec_r  <= sec_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

[rtl/dual_relay_pulse_controller_unit.sv]
// dual relay pulse controller
// input channel in_valid / in_stall / in_data carries one task tick per beat,
// with an optional command (set, pulse one/two/both, status query).
// output channel out_valid / out_stall / out_data returns exactly one beat
// per input beat: both relay levels after that tick and the query reply.
// cfg_we / cfg_wdata write the ticks-per-second register; write it only
// while no tick is in flight.
// path: an accepted beat is held in the input register, then processed and
// captured in the output register once the output is empty or not stalled,
// from where its result is offered.
// throughput: one beat per cycle while out_stall is low; the tick is a single
// pass of decode, tick and second increment and compare per relay channel.
// stall: while the output beat waits, the input register still takes one
// beat; only when both are full does in_stall rise.
// reset (synchronous, rst_n low): relays off, status bits zero, pulses idle,
// no pending starts, counters zero, ticks per second back to 100.
module dual_relay_pulse_controller_unit
  import drpc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [TpsW-1:0] cfg_wdata
);

  logic            in_valid_r;
  in_item_t        in_data_r;
  logic            out_valid_r;
  out_item_t       out_data_r, out_data_nxt;
  logic [TpsW-1:0] tps_r;
  logic [1:0]      relay_r, relay_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            advance;
  cmd_dec_t        dec;
  chan_req_t       req_one, req_two;
  chan_act_t       act_one, act_two;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  drpc_cmd_dec u_dec (
    .item (in_data_r),
    .dec  (dec)
  );

  assign req_one.start  = dec.pulse_one;
  assign req_one.length = {in_data_r.param_high, in_data_r.param_low};
  assign req_two.start  = dec.pulse_two;
  assign req_two.length = {in_data_r.param_high, in_data_r.param_low};

  drpc_pulse_chan u_chan_one (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_one),
    .tps     (tps_r),
    .act     (act_one)
  );

  drpc_pulse_chan u_chan_two (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_two),
    .tps     (tps_r),
    .act     (act_two)
  );

  // command first, then relay one pulse, then relay two pulse
  always_comb begin
    status_nxt = status_r;
    relay_nxt  = relay_r;
    if (dec.set) begin
      status_nxt = in_data_r.param_high[1:0];
      relay_nxt  = in_data_r.param_high[1:0];
    end
    if (act_one.drive_on)  relay_nxt[RelayOneIdx] = 1'b1;
    if (act_one.drive_off) relay_nxt[RelayOneIdx] = 1'b0;
    if (act_two.drive_on)  relay_nxt[RelayTwoIdx] = 1'b1;
    if (act_two.drive_off) relay_nxt[RelayTwoIdx] = 1'b0;

    out_data_nxt.relay_one_level = relay_nxt[RelayOneIdx];
    out_data_nxt.relay_two_level = relay_nxt[RelayTwoIdx];
    out_data_nxt.reply_valid     = dec.query;
    out_data_nxt.reply_status    = dec.query ? status_r : 2'b00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tps_r       <= TpsReset;
      relay_r     <= 2'b00;
      status_r    <= 2'b00;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        relay_r     <= relay_nxt;
        status_r    <= status_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.reply_valid |-> out_data_r.reply_status == 2'b00)
    else $error("reply status set without a reply");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed beat did not reach the output register");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_data_r))
    else $error("held input beat lost or changed");

  a_levels_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_data_r.relay_one_level == relay_r[RelayOneIdx]
             && out_data_r.relay_two_level == relay_r[RelayTwoIdx])
    else $error("output levels differ from relay state");

endmodule
